// File: design/tdwm_pkg.sv
package tdwm_pkg;

  localparam int STATE_W  = 4;
  localparam int SYMBOL_W = 8;

  typedef enum logic [1:0] {
    REQ_LOAD_TRANS  = 2'd0,
    REQ_LOAD_ACCEPT = 2'd1,
    REQ_SYMBOL      = 2'd2,
    REQ_END         = 2'd3
  } req_t;

  typedef enum logic {
    MODE_CLEAR = 1'b0,
    MODE_RUN   = 1'b1
  } mode_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } entry_t;

  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] final_state;
    logic               died;
  } result_t;

endpackage

// File: design/table_dfa_word_matcher.sv
// Table-driven word acceptor.
// Input channel (in_valid/in_ready) carries one request per transaction: load a
// transition entry, load an accepting flag, step the current word on a symbol,
// or end the word. Only end-of-word transactions produce a result on the output
// channel (out_valid/out_ready): accepted flag, final state and died flag.
// cfg_wr_en/cfg_wr_data write the start state.
// Throughput: one transaction per cycle while in_ready is high, symbols included.
// A symbol reads the transition memory at the accept edge; the registered read
// data resolves the current state in the next cycle and feeds the next read
// address directly. The result of an end of word is registered into the output
// register, or into the skid entry while the output register is stalled.
// Stalls: an output register plus one skid entry hold results; in_ready drops
// while the skid entry is occupied and while the memory is swept after reset.
// Reset: control state clears at once, then the transition memory is swept to
// "no transition", one entry per cycle, over all STATE_COUNT*SYMBOL_COUNT entries
// (4096 by default), with in_ready low. Configuration writes are taken out of reset.
module table_dfa_word_matcher #(
  parameter int STATE_COUNT  = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_from_state,
  input  logic [7:0] in_symbol,
  input  logic       in_next_valid,
  input  logic [3:0] in_next_state,
  input  logic       in_accepting,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_word_accepted,
  output logic [3:0] out_final_state,
  output logic       out_died,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  localparam int DEPTH   = STATE_COUNT * SYMBOL_COUNT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ACC_N   = (STATE_COUNT < 16) ? STATE_COUNT : 16;
  localparam int ACC_IW  = $clog2(ACC_N);
  localparam int ENTRY_W = $bits(tdwm_pkg::entry_t);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] SYM_CNT_A = ADDR_W'(SYMBOL_COUNT);
  localparam logic [8:0]        STATE_LIM = 9'(STATE_COUNT);
  localparam logic [8:0]        SYM_LIM   = 9'(SYMBOL_COUNT);

  tdwm_pkg::mode_t   mode_r, mode_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [3:0]        start_r;
  logic [3:0]        cur_r, cur_nxt;
  logic              dead_r, dead_nxt;
  logic              inw_r, inw_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_ok_r, pend_ok_nxt;
  logic [ACC_N-1:0]  acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  tdwm_pkg::result_t out_res_r, out_res_nxt;
  logic              skid_v_r, skid_v_nxt;
  tdwm_pkg::result_t skid_r, skid_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  tdwm_pkg::entry_t  ram_wentry;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  tdwm_pkg::entry_t  rd_entry;

  tdwm_pkg::req_t    req;
  tdwm_pkg::result_t res;
  logic              in_accept;
  logic              push;
  logic              out_free;
  logic [3:0]        eff_cur;
  logic              eff_dead;
  logic [3:0]        base_st;
  logic              base_dead;
  logic              base_ok;
  logic              from_ok;
  logic              sym_ok;
  logic              tgt_ok;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] st, input logic [7:0] sym);
    addr_of = ADDR_W'(st) * SYM_CNT_A + ADDR_W'(sym);
  endfunction

  tdwm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wentry)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry  = tdwm_pkg::entry_t'(ram_rdata);
  assign req       = tdwm_pkg::req_t'(in_req_type);
  assign in_ready  = (mode_r == tdwm_pkg::MODE_RUN) && !skid_v_r;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    eff_cur  = cur_r;
    eff_dead = dead_r;
    if (pend_r) begin
      if (pend_ok_r && rd_entry.valid) begin
        eff_cur = rd_entry.target;
      end else begin
        eff_dead = 1'b1;
      end
    end
    base_st   = inw_r ? eff_cur : start_r;
    base_dead = inw_r ? eff_dead : 1'b0;
    base_ok   = {5'd0, base_st} < STATE_LIM;
    from_ok   = {5'd0, in_from_state} < STATE_LIM;
    tgt_ok    = {5'd0, in_next_state} < STATE_LIM;
    sym_ok    = {1'b0, in_symbol} < SYM_LIM;
  end

  always_comb begin
    mode_nxt    = mode_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt     = eff_cur;
    dead_nxt    = eff_dead;
    inw_nxt     = inw_r;
    pend_nxt    = 1'b0;
    pend_ok_nxt = pend_ok_r;
    acc_nxt     = acc_r;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wentry  = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    push        = 1'b0;
    res         = '0;

    unique case (mode_r)
      tdwm_pkg::MODE_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          mode_nxt = tdwm_pkg::MODE_RUN;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      tdwm_pkg::MODE_RUN: begin
        if (in_accept) begin
          unique case (req)
            tdwm_pkg::REQ_LOAD_TRANS: begin
              if (from_ok && sym_ok) begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(in_from_state, in_symbol);
                if (in_next_valid && tgt_ok) begin
                  ram_wentry.valid  = 1'b1;
                  ram_wentry.target = in_next_state;
                end
              end
            end
            tdwm_pkg::REQ_LOAD_ACCEPT: begin
              if (from_ok) begin
                acc_nxt[in_from_state[ACC_IW-1:0]] = in_accepting;
              end
            end
            tdwm_pkg::REQ_SYMBOL: begin
              inw_nxt  = 1'b1;
              cur_nxt  = base_st;
              dead_nxt = base_dead;
              if (!base_dead) begin
                ram_re      = 1'b1;
                pend_nxt    = 1'b1;
                pend_ok_nxt = base_ok && sym_ok;
                if (base_ok && sym_ok) begin
                  ram_raddr = addr_of(base_st, in_symbol);
                end
              end
            end
            tdwm_pkg::REQ_END: begin
              push            = 1'b1;
              res.accepted    = !base_dead && base_ok && acc_r[base_st[ACC_IW-1:0]];
              res.final_state = base_st;
              res.died        = base_dead;
              cur_nxt         = start_r;
              dead_nxt        = 1'b0;
              inw_nxt         = 1'b0;
            end
          endcase
        end
      end
    endcase
  end

  // hold a result in the skid entry while the output register is stalled
  always_comb begin
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    skid_v_nxt    = skid_v_r;
    skid_nxt      = skid_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_res_nxt   = skid_r;
        out_valid_nxt = 1'b1;
        skid_v_nxt    = 1'b0;
      end else if (push) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tdwm_pkg::MODE_CLEAR;
      clr_cnt_r   <= '0;
      start_r     <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      inw_r       <= 1'b0;
      pend_r      <= 1'b0;
      pend_ok_r   <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      inw_r       <= inw_nxt;
      pend_r      <= pend_nxt;
      pend_ok_r   <= pend_ok_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skid_r    <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_word_accepted = out_res_r.accepted;
  assign out_final_state   = out_res_r.final_state;
  assign out_died          = out_res_r.died;

endmodule

// File: design/tdwm_ram.sv
module tdwm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
